/* design/lir_pkg.sv */
package lir_pkg;

   localparam int MAX_UPSAMPLE = 8;
   localparam int SAMPLE_W = 32;
   localparam int RATIO_W = 31;
   localparam int PHASE_W = 32;
   localparam int OUT_W = 16;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int FRAC_W = 28;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;
   localparam int WIDE_W = SAMPLE_W + 3;
   localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PHASE_W-1:0] FX_ONE = 32'h1000_0000;
   localparam logic [RATIO_W-1:0] RATIO_ONE = 31'h1000_0000;
   localparam logic [RATIO_W-1:0] RATIO_MAX = 31'h6000_0000;
   localparam logic [RATIO_W-1:0] RATIO_MIN =
      RATIO_W'((64'h1000_0000 + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE);
   localparam logic [PHASE_W-1:0] SNAP_ADD = 32'h0000_0080;
   localparam logic [PHASE_W-1:0] SNAP_MASK = 32'h0fff_ff00;
   localparam logic [PHASE_W-1:0] INT_MASK = 32'hf000_0000;
   localparam logic signed [WIDE_W-1:0] WIDE_ONE = 35'sd268435456;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sd32767;

   typedef enum logic {
      CSR_RATE_RATIO = 1'b0,
      CSR_MONO_MODE  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_PRIME,
      KIND_INTERP
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_EMIT,
      BK_PASS
   } back_state_type;

   typedef struct packed {
      kind_type                    kind;
      logic                        mono;
      logic [RATIO_W-1:0]          ratio;
      logic signed [SAMPLE_W-1:0]  left;
      logic signed [SAMPLE_W-1:0]  right;
   } job_type;

   // floor(v / 2^13); v at or beyond +-2^28 saturates to +-32767
   function automatic logic signed [OUT_W-1:0] to_short(input logic signed [WIDE_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v >= WIDE_ONE) begin
         r = OUT_MAX;
      end else if (v <= -WIDE_ONE) begin
         r = -OUT_MAX;
      end else begin
         r = v[28:13];
      end
      return r;
   endfunction

endpackage

/* design/lir_chan_if.sv */
interface lir_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lir_pkg::SAMPLE_W-1:0]  left_sample;
   logic signed [lir_pkg::SAMPLE_W-1:0]  right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface lir_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [lir_pkg::OUT_W-1:0]  left_out;
   logic signed [lir_pkg::OUT_W-1:0]  right_out;
   logic                              last_of_run;

   modport source (output valid, output left_out, output right_out, output last_of_run,
                   input ready);
   modport sink (input valid, input left_out, input right_out, input last_of_run,
                 output ready);
endinterface

/* design/linear_interp_resampler.sv */
// A request passes through its queue entry, the back end state, the product registers and
// the output registers before its first result is valid; pass-through skips the products.
// Each upsampling result takes a multiply step (BK_RUN), then a saturate step (BK_EMIT);
// the back end finishes one request before taking the next and stalls while rsp is held.
// A 2-entry queue lets the front accept while the back end works.
// Reset (synchronous, active high) clears state, phase, history, queue count and CSRs.
module linear_interp_resampler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  lir_pkg::csr_index_type        csr_index,
   input  logic [lir_pkg::RATIO_W-1:0]   csr_wdata,
   lir_req_if.sink                       req_bus,
   lir_rsp_if.source                     rsp_bus
);
   import lir_pkg::*;

   job_type front_job, back_job;
   logic    front_valid, front_ready;
   logic    back_valid, back_ready;

   lir_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req          (req_bus),
      .job_valid    (front_valid),
      .job_ready    (front_ready),
      .job          (front_job)
   );

   lir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_job    (back_job)
   );

   lir_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job       (back_job),
      .rsp       (rsp_bus)
   );

endmodule

/* design/lir_front.sv */
module lir_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  lir_pkg::csr_index_type        csr_index,
   input  logic [lir_pkg::RATIO_W-1:0]   csr_wdata,
   lir_req_if.sink                       req,
   output logic                          job_valid,
   input  logic                          job_ready,
   output lir_pkg::job_type              job
);
   import lir_pkg::*;

   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic               mono_ff, mono_in;
   logic               primed_ff, primed_in;
   logic               accept;

   assign req.ready = job_ready;
   assign job_valid = req.valid;
   assign accept = req.valid && job_ready;

   always_comb begin
      ratio_in = ratio_ff;
      mono_in = mono_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RATE_RATIO: ratio_in = csr_wdata;
            CSR_MONO_MODE:  mono_in = csr_wdata[0];
            default: ;
         endcase
      end
      primed_in = primed_ff | accept;
   end

   always_comb begin
      job.mono = mono_ff;
      job.left = req.left_sample;
      job.right = mono_ff ? req.left_sample : req.right_sample;
      if (ratio_ff == RATIO_ONE) begin
         job.kind = KIND_PASS;
      end else if (!primed_ff) begin
         job.kind = KIND_PRIME;
      end else begin
         job.kind = KIND_INTERP;
      end
      if (ratio_ff < RATIO_MIN) begin
         job.ratio = RATIO_MIN;
      end else if (ratio_ff > RATIO_MAX) begin
         job.ratio = RATIO_MAX;
      end else begin
         job.ratio = ratio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_ONE;
         mono_ff <= 1'b0;
         primed_ff <= 1'b0;
      end else begin
         ratio_ff <= ratio_in;
         mono_ff <= mono_in;
         primed_ff <= primed_in;
      end
   end

endmodule

/* design/lir_queue.sv */
module lir_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lir_pkg::job_type  push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lir_pkg::job_type  pop_job
);
   import lir_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_job = entry_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* design/lir_back.sv */
module lir_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  lir_pkg::job_type  job,
   lir_rsp_if.source         rsp
);
   import lir_pkg::*;

   back_state_type              state_ff, state_in;
   logic signed [SAMPLE_W-1:0]  prev_l_ff, prev_l_in;
   logic signed [SAMPLE_W-1:0]  prev_r_ff, prev_r_in;
   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]    prod_l_ff, prod_l_in;
   logic signed [PROD_W-1:0]    prod_r_ff, prod_r_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]     left_out_ff, left_out_in;
   logic signed [OUT_W-1:0]     right_out_ff, right_out_in;
   logic                        last_ff, last_in;

   logic                        out_free;
   logic                        run_more;
   logic signed [DIFF_W-1:0]    diff_l, diff_r;
   logic signed [FRAC_W:0]      frac;
   logic [PHASE_W-1:0]          phase_sum, snap_sum, phase_step, phase_end;
   logic signed [WIDE_W-1:0]    val_l, val_r;
   logic signed [OUT_W-1:0]     short_l;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.left_out = left_out_ff;
   assign rsp.right_out = right_out_ff;
   assign rsp.last_of_run = last_ff;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign run_more = (phase_ff < FX_ONE) && (cnt_ff < CNT_W'(MAX_UPSAMPLE));

   assign diff_l = DIFF_W'(job.left) - DIFF_W'(prev_l_ff);
   assign diff_r = DIFF_W'(job.right) - DIFF_W'(prev_r_ff);
   assign frac = {1'b0, phase_ff[FRAC_W-1:0]};
   assign phase_sum = phase_ff + PHASE_W'(job.ratio);
   assign snap_sum = phase_sum + SNAP_ADD;
   assign phase_step = ((snap_sum & SNAP_MASK) == '0) ? (snap_sum & INT_MASK) : phase_sum;
   assign phase_end = ((phase_ff < FX_ONE) ? FX_ONE : phase_ff) - FX_ONE;
   assign val_l = WIDE_W'(prev_l_ff) + WIDE_W'(prod_l_ff >>> FRAC_W);
   assign val_r = WIDE_W'(prev_r_ff) + WIDE_W'(prod_r_ff >>> FRAC_W);
   assign short_l = to_short(val_l);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               case (job.kind)
                  KIND_PASS:   state_in = BK_PASS;
                  KIND_INTERP: state_in = BK_RUN;
                  default:     state_in = BK_IDLE;
               endcase
            end
         end
         BK_RUN:  state_in = run_more ? BK_EMIT : BK_IDLE;
         BK_EMIT: state_in = out_free ? BK_RUN : BK_EMIT;
         BK_PASS: state_in = out_free ? BK_IDLE : BK_PASS;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      job_ready = 1'b0;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      prod_l_in = prod_l_ff;
      prod_r_in = prod_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      left_out_in = left_out_ff;
      right_out_in = right_out_ff;
      last_in = last_ff;
      case (state_ff)
         BK_IDLE: begin
            cnt_in = '0;
            if (job_valid && job.kind == KIND_PRIME) begin
               prev_l_in = job.left;
               prev_r_in = job.right;
               phase_in = '0;
               job_ready = 1'b1;
            end
         end
         BK_RUN: begin
            if (run_more) begin
               prod_l_in = PROD_W'(diff_l * frac);
               prod_r_in = PROD_W'(diff_r * frac);
               phase_in = phase_step;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               phase_in = phase_end;
               prev_l_in = job.left;
               prev_r_in = job.right;
               job_ready = 1'b1;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               left_out_in = short_l;
               right_out_in = job.mono ? short_l : to_short(val_r);
               last_in = !run_more;
            end
         end
         BK_PASS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               left_out_in = to_short(WIDE_W'(job.left));
               right_out_in = to_short(WIDE_W'(job.right));
               last_in = 1'b1;
               prev_l_in = job.left;
               prev_r_in = job.right;
               job_ready = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
      left_out_ff <= left_out_in;
      right_out_ff <= right_out_in;
      last_ff <= last_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
         phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_RUN || state_ff == BK_EMIT) |-> cnt_ff <= CNT_W'(MAX_UPSAMPLE))
      else $error("run count beyond upsample limit");
   a_emit_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT) |-> cnt_ff != '0)
      else $error("emit without a counted step");
   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT && out_free) |=> rsp_valid_ff)
      else $error("emitted request not presented");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      job_ready |-> job_valid)
      else $error("pop from empty queue");
`endif

endmodule

/* bench/linear_interp_resampler_tb.sv */
`timescale 1ns / 100ps

module linear_interp_resampler_tb;
   import lir_pkg::*;

   localparam logic [31:0] Q_ONE = 32'h1000_0000;
   localparam longint WIDE_ONE = 64'sd268435456;
   localparam logic [30:0] RATIO_UNITY = 31'h1000_0000;
   localparam logic [31:0] RATIO_FLOOR = 32'h0200_0000;
   localparam logic [31:0] RATIO_CEIL = 32'h6000_0000;
   localparam logic [31:0] SNAP_BIAS = 32'h0000_0080;
   localparam logic [31:0] SNAP_FIELD = 32'h0fff_ff00;
   localparam logic [31:0] WHOLE_FIELD = 32'hf000_0000;
   localparam logic signed [15:0] PCM_MAX = 16'sd32767;
   localparam int MAX_RUN = 8;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 25;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               last;
   } pcm_frame_type;

   typedef enum {
      STEP_CSR,
      STEP_REQ,
      STEP_REQ_KNOWN
   } step_kind_type;

   typedef struct {
      step_kind_type       kind;
      csr_index_type       idx;
      logic [30:0]         wdata;
      logic signed [31:0]  l;
      logic signed [31:0]  r;
      logic signed [15:0]  pl;
      logic signed [15:0]  pr;
   } plan_row_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   csr_index_type csr_index;
   logic [RATIO_W-1:0] csr_wdata;

   lir_req_if req_bus();
   lir_rsp_if rsp_bus();

   linear_interp_resampler dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // predictor state and register shadow
   logic [30:0]        ratio_cfg;
   logic               mono_cfg;
   logic signed [31:0] hist_left;
   logic signed [31:0] hist_right;
   logic [31:0]        phase_acc;
   logic               primed;

   pcm_frame_type pcm_expected[$];
   int fail_count;
   int cycle_count;
   bit steady;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pace_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   function automatic logic signed [15:0] to_pcm16(input longint v);
      if (v >= WIDE_ONE) return PCM_MAX;
      if (v <= -WIDE_ONE) return -PCM_MAX;
      return 16'(v >>> 13);
   endfunction

   // prev + floor((cur - prev) * ph / 2^28), kept wide
   function automatic longint blend(input logic signed [31:0] a, input longint b,
                                    input logic [31:0] ph);
      longint base;
      longint prod;
      base = a;
      prod = (b - base) * longint'({32'd0, ph});
      return base + (prod >>> 28);
   endfunction

   function automatic void resample_step(input logic signed [31:0] li, ri,
                                         output pcm_frame_type res[$]);
      logic signed [31:0] cl;
      logic signed [31:0] cr;
      logic [31:0] step;
      pcm_frame_type f;
      int n;
      res = {};
      cl = li;
      cr = mono_cfg ? li : ri;
      if (ratio_cfg == RATIO_UNITY) begin
         f.left = to_pcm16(cl);
         f.right = mono_cfg ? f.left : to_pcm16(cr);
         f.last = 1'b1;
         res.push_back(f);
         hist_left = cl;
         hist_right = cr;
         primed = 1'b1;
         return;
      end
      if (!primed) begin
         hist_left = cl;
         hist_right = cr;
         phase_acc = '0;
         primed = 1'b1;
         return;
      end
      step = {1'b0, ratio_cfg};
      if (step < RATIO_FLOOR) step = RATIO_FLOOR;
      if (step > RATIO_CEIL) step = RATIO_CEIL;
      n = 0;
      while (phase_acc < Q_ONE && n < MAX_RUN) begin
         f.left = to_pcm16(blend(hist_left, cl, phase_acc));
         f.right = mono_cfg ? f.left : to_pcm16(blend(hist_right, cr, phase_acc));
         f.last = 1'b0;
         res.push_back(f);
         n++;
         phase_acc += step;
         if (((phase_acc + SNAP_BIAS) & SNAP_FIELD) == '0)
            phase_acc = (phase_acc + SNAP_BIAS) & WHOLE_FIELD;
      end
      if (phase_acc < Q_ONE) phase_acc = Q_ONE;
      phase_acc -= Q_ONE;
      if (n > 0) begin
         f = res[n-1];
         f.last = 1'b1;
         res[n-1] = f;
      end
      hist_left = cl;
      hist_right = cr;
   endfunction

   function automatic logic signed [31:0] rand_sample();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $signed($urandom_range(0, 32'h1fff_fffe)) - 32'sh0fff_ffff;
         4, 5: v = $urandom;
         6: begin
            case ($urandom_range(0, 6))
               0: v = 32'sh7fff_ffff;
               1: v = 32'sh8000_0000;
               2: v = 32'sh1000_0000;
               3: v = 32'shf000_0000;
               4: v = 32'sh0fff_ffff;
               5: v = 32'shf000_0001;
               default: v = '0;
            endcase
         end
         7: v = $signed($urandom_range(0, 65535)) - 32'sd32768;
         default: v = ($urandom_range(0, 1) ? 32'sh1000_0000 : 32'shf000_0000)
                      + $signed($urandom_range(0, 16383)) - 32'sd8192;
      endcase
      return v;
   endfunction

   function automatic plan_row_type wr(input csr_index_type idx, input logic [30:0] val);
      plan_row_type row;
      row = '{STEP_CSR, idx, val, '0, '0, '0, '0};
      return row;
   endfunction

   function automatic plan_row_type rq(input logic signed [31:0] l, r);
      plan_row_type row;
      row = '{STEP_REQ, CSR_RATE_RATIO, '0, l, r, '0, '0};
      return row;
   endfunction

   function automatic plan_row_type pin(input logic signed [31:0] l, r,
                                        input logic signed [15:0] pl, pr);
      plan_row_type row;
      row = '{STEP_REQ_KNOWN, CSR_RATE_RATIO, '0, l, r, pl, pr};
      return row;
   endfunction

   // lower valid, wait out every pending result and the back end's tail
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pcm_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [30:0] val);
      settle();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_RATE_RATIO) ratio_cfg = val;
      else mono_cfg = val[0];
   endtask

   task automatic send_pair(input logic signed [31:0] l, r, input bit known,
                            input logic signed [15:0] pl, pr);
      pcm_frame_type got[$];
      int g;
      g = pace_gap();
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.left_sample <= l;
      req_bus.right_sample <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      resample_step(l, r, got);
      if (known) pcm_expected.push_back('{pl, pr, 1'b1});
      else foreach (got[i]) pcm_expected.push_back(got[i]);
   endtask

   initial begin : rsp_pace
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            hold = pace_gap();
            rsp_bus.ready <= (hold == 0);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      pcm_frame_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pcm_expected.size() == 0) begin
            $display("%0t: result with none pending: left %0d right %0d last %0b",
                     $time, rsp_bus.left_out, rsp_bus.right_out, rsp_bus.last_of_run);
            fail_count++;
         end else begin
            want = pcm_expected.pop_front();
            if (rsp_bus.left_out !== want.left) begin
               $display("%0t: left_out expected %0d actual %0d",
                        $time, want.left, rsp_bus.left_out);
               fail_count++;
            end
            if (rsp_bus.right_out !== want.right) begin
               $display("%0t: right_out expected %0d actual %0d",
                        $time, want.right, rsp_bus.right_out);
               fail_count++;
            end
            if (rsp_bus.last_of_run !== want.last) begin
               $display("%0t: last_of_run expected %0b actual %0b",
                        $time, want.last, rsp_bus.last_of_run);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      plan_row_type plan[$];
      logic [30:0] ratio;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_RATE_RATIO;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.left_sample = '0;
      req_bus.right_sample = '0;
      fail_count = 0;
      cycle_count = 0;
      steady = 1'b0;
      ratio_cfg = RATIO_UNITY;
      mono_cfg = 1'b0;
      hist_left = '0;
      hist_right = '0;
      phase_acc = '0;
      primed = 1'b0;

      // first request primes, then wide differences at 3/4
      plan.push_back(wr(CSR_RATE_RATIO, 31'h0c00_0000));
      plan.push_back(rq(32'sh0800_0000, 32'shf800_0000));
      plan.push_back(rq(32'sh7fff_ffff, 32'sh8000_0000));
      plan.push_back(rq(32'sh8000_0000, 32'sh7fff_ffff));
      plan.push_back(rq(32'sh0000_0000, 32'sh0000_0000));
      plan.push_back(rq(32'sh0fff_ffff, 32'shf000_0001));
      // below the floor: clamps to 1/8, up to eight results each
      plan.push_back(wr(CSR_RATE_RATIO, 31'h0000_0001));
      plan.push_back(rq(32'sh0800_0000, 32'shf800_0000));
      plan.push_back(rq(32'sh0000_1fff, 32'shffff_e000));
      // above the ceiling: clamps to 6, mostly skipped
      plan.push_back(wr(CSR_RATE_RATIO, 31'h7fff_ffff));
      plan.push_back(rq(32'sh0123_4567, 32'shfedc_ba98));
      plan.push_back(rq(32'sh0765_4321, 32'sh8765_4321));
      plan.push_back(rq(32'shf555_5555, 32'sh0aaa_aaaa));
      plan.push_back(rq(32'sh7000_0000, 32'sh9000_0000));
      // one third: phase lands a hair under one and snaps
      plan.push_back(wr(CSR_RATE_RATIO, 31'h0555_5555));
      plan.push_back(rq(32'sh0400_0000, 32'shfc00_0000));
      plan.push_back(rq(32'shf800_0000, 32'sh0800_0000));
      plan.push_back(rq(32'sh0000_3000, 32'shffff_d000));
      plan.push_back(wr(CSR_MONO_MODE, 31'd1));
      plan.push_back(rq(32'sh0200_0000, 32'sh7fff_ffff));
      plan.push_back(rq(32'shfe00_0000, 32'sh8000_0000));
      // pass-through
      plan.push_back(wr(CSR_RATE_RATIO, RATIO_UNITY));
      plan.push_back(pin(32'sh7fff_ffff, 32'sh8000_0000, 16'sd32767, 16'sd32767));
      plan.push_back(wr(CSR_MONO_MODE, 31'd0));
      plan.push_back(pin(32'sh0000_0000, 32'sh0000_0000, 16'sd0, 16'sd0));
      plan.push_back(pin(32'sh7fff_ffff, 32'sh8000_0000, 16'sd32767, -16'sd32767));
      plan.push_back(pin(32'sh1000_0000, 32'shf000_0000, 16'sd32767, -16'sd32767));
      plan.push_back(pin(32'sh0fff_ffff, 32'shf000_0001, 16'sd32767, -16'sd32768));
      plan.push_back(pin(32'sh0000_2000, 32'shffff_ffff, 16'sd1, -16'sd1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         case (plan[i].kind)
            STEP_CSR: write_reg(plan[i].idx, plan[i].wdata);
            STEP_REQ: send_pair(plan[i].l, plan[i].r, 1'b0, '0, '0);
            default: send_pair(plan[i].l, plan[i].r, 1'b1, plan[i].pl, plan[i].pr);
         endcase
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: ratio = RATIO_FLOOR[30:0];
            1: ratio = RATIO_CEIL[30:0];
            2: ratio = 31'h0eb3_3333;
            3: ratio = 31'h1166_6666;
            4: ratio = '0;
            5: ratio = 31'($urandom_range(RATIO_FLOOR, RATIO_CEIL));
            6: ratio = RATIO_UNITY;
            default: ratio = 31'($urandom);
         endcase
         write_reg(CSR_RATE_RATIO, ratio);
         write_reg(CSR_MONO_MODE, (p == 2) ? 31'd1 : (p == 3) ? 31'd0
                                           : 31'($urandom_range(0, 1)));
         steady = (p == 5);
         repeat (ITEMS_PER_PHASE) send_pair(rand_sample(), rand_sample(), 1'b0, '0, '0);
      end
      steady = 1'b0;

      settle();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
